// ===== sv/text_stream_line_formatter_defines.svh =====
// Assertion macros used by the checker.
`ifndef TEXT_STREAM_LINE_FORMATTER_DEFINES_SVH
`define TEXT_STREAM_LINE_FORMATTER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TSLF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TSLF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/tslf_pkg.sv =====
package tslf_pkg;

    localparam int NUMBER_DIGITS = 6;
    localparam int BCD_W         = 4 * NUMBER_DIGITS;
    localparam int PREFIX_LEN    = NUMBER_DIGITS + 2;
    localparam int IDX_W         = (PREFIX_LEN > 1) ? $clog2(PREFIX_LEN) : 1;
    localparam int CFG_IDX_W     = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SQUEEZE_BLANK   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_ALL      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_NONBLANK = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOW_TABS       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOW_ENDS       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOW_CONTROL    = 3'd5;

    // characters
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_DOLLAR   = 8'h24;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_I        = 8'h49;
    localparam logic [7:0] CH_CARET    = 8'h5E;
    localparam logic [7:0] CTRL_OFFSET = 8'h40;

    localparam logic [3:0] BCD_NINE = 4'd9;
    localparam logic [3:0] BCD_ZERO = 4'd0;

    localparam logic [1:0] RUN_DROP = 2'd2;
    localparam logic [1:0] RUN_MAX  = 2'd3;

    typedef struct packed {
        logic             load;       // take the input word
        logic             emit;       // load the output register
        logic             phase_num;  // emitting line-number prefix
        logic             last;       // final word of this run
        logic [IDX_W-1:0] idx;        // position within the phase
    } tslf_cmd_t;

    typedef struct packed {
        logic drop;      // input word is a squeezed newline
        logic num;       // input word starts a numbered line
        logic body_two;  // latched body is two words long
    } tslf_status_t;

endpackage

// ===== sv/tslf_ifs.sv =====
interface tslf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       file_start;

    modport source (output valid, output in_byte, output file_start, input ready);
    modport sink   (input valid, input in_byte, input file_start, output ready);
endinterface

interface tslf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

interface tslf_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic       data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/tslf_ctrl.sv =====
module tslf_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  out_ready,
    output logic                  out_valid,
    output tslf_pkg::tslf_cmd_t   cmd,
    input  tslf_pkg::tslf_status_t status
);
    import tslf_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_NUM  = 2'd1;
    localparam logic [1:0] ST_BODY = 2'd2;

    localparam logic [IDX_W-1:0] IDX_PREFIX_END = IDX_W'(PREFIX_LEN - 1);
    localparam logic [IDX_W-1:0] IDX_ONE        = IDX_W'(1);

    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;
    logic             slot_free;
    logic             accept;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        cmd.load      = 1'b0;
        cmd.emit      = 1'b0;
        cmd.phase_num = (state_reg == ST_NUM);
        cmd.last      = 1'b0;
        cmd.idx       = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load = 1'b1;
                    idx_next = '0;
                    if (!status.drop)
                    begin
                        state_next = status.num ? ST_NUM : ST_BODY;
                    end
                end
            end
            ST_NUM:
            begin
                if (slot_free)
                begin
                    cmd.emit = 1'b1;
                    if (idx_reg == IDX_PREFIX_END)
                    begin
                        state_next = ST_BODY;
                        idx_next   = '0;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_ONE;
                    end
                end
            end
            ST_BODY:
            begin
                cmd.last = !status.body_two || (idx_reg == IDX_ONE);
                if (slot_free)
                begin
                    cmd.emit = 1'b1;
                    if (cmd.last)
                    begin
                        state_next = ST_IDLE;
                        idx_next   = '0;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_ONE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                idx_next   = '0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== sv/tslf_dp.sv =====
module tslf_dp
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [tslf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic                            cfg_data,
    input  logic [7:0]                      in_byte,
    input  logic                            file_start,
    input  tslf_pkg::tslf_cmd_t             cmd,
    output tslf_pkg::tslf_status_t          status,
    output logic [7:0]                      out_byte,
    output logic                            last_of_run
);
    import tslf_pkg::*;

    // configuration
    logic squeeze_reg, number_all_reg, nonblank_reg;
    logic show_tabs_reg, show_ends_reg, show_control_reg;

    // line state
    logic [BCD_W-1:0] count_reg, count_next;
    logic [1:0]       run_reg, run_next;
    logic             als_reg, als_next;

    // latched body words
    logic [7:0] body0_reg, body0_next;
    logic [7:0] body1_reg, body1_next;
    logic       body_two_reg, body_two_next;

    logic [7:0] out_byte_reg, out_byte_next;
    logic       last_reg;

    logic [1:0] run_fs;
    logic       als_fs;
    logic       is_lf, is_tab, is_ctrl;
    logic       tab_caret, end_mark, ctrl_caret;
    logic       drop, num;

    logic [3:0] dig     [NUMBER_DIGITS];
    logic [3:0] inc_dig [NUMBER_DIGITS];
    logic [BCD_W-1:0] count_inc;
    logic             all_nines;
    logic [7:0] prefix_chars [PREFIX_LEN];

    // config writes; indexes past the list are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            squeeze_reg      <= 1'b0;
            number_all_reg   <= 1'b0;
            nonblank_reg     <= 1'b0;
            show_tabs_reg    <= 1'b0;
            show_ends_reg    <= 1'b0;
            show_control_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SQUEEZE_BLANK:   squeeze_reg      <= cfg_data;
                CFG_NUMBER_ALL:      number_all_reg   <= cfg_data;
                CFG_NUMBER_NONBLANK: nonblank_reg     <= cfg_data;
                CFG_SHOW_TABS:       show_tabs_reg    <= cfg_data;
                CFG_SHOW_ENDS:       show_ends_reg    <= cfg_data;
                CFG_SHOW_CONTROL:    show_control_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    // BCD increment, held at all nines
    always_comb
    begin
        logic low_nine;
        low_nine = 1'b1;
        for (int i = 0; i < NUMBER_DIGITS; i++)
        begin
            dig[i] = count_reg[4*i +: 4];
            if (low_nine)
                inc_dig[i] = (dig[i] == BCD_NINE) ? BCD_ZERO : dig[i] + 4'd1;
            else
                inc_dig[i] = dig[i];
            low_nine = low_nine && (dig[i] == BCD_NINE);
        end
        all_nines = low_nine;
        for (int i = 0; i < NUMBER_DIGITS; i++)
        begin
            count_inc[4*i +: 4] = inc_dig[i];
        end
    end

    // prefix text from the stored count; leading zeros blank
    always_comb
    begin
        logic zero_above;
        zero_above = 1'b1;
        for (int p = NUMBER_DIGITS - 1; p >= 0; p--)
        begin
            zero_above = zero_above && (dig[p] == BCD_ZERO);
            if (zero_above && (p != 0))
                prefix_chars[NUMBER_DIGITS-1-p] = CH_SPACE;
            else
                prefix_chars[NUMBER_DIGITS-1-p] = CH_ZERO + {4'b0000, dig[p]};
        end
        prefix_chars[NUMBER_DIGITS]     = CH_SPACE;
        prefix_chars[NUMBER_DIGITS + 1] = CH_SPACE;
    end

    // input word decode
    always_comb
    begin
        run_fs     = file_start ? 2'd0 : run_reg;
        als_fs     = file_start || als_reg;
        is_lf      = (in_byte == CH_LF);
        is_tab     = (in_byte == CH_TAB);
        is_ctrl    = (in_byte < CH_SPACE) && !is_lf && !is_tab;
        drop       = is_lf && squeeze_reg && (run_fs >= RUN_DROP);
        num        = als_fs && (nonblank_reg ? !is_lf : number_all_reg);
        tab_caret  = is_tab && show_tabs_reg;
        end_mark   = is_lf && show_ends_reg;
        ctrl_caret = show_control_reg && is_ctrl;

        if (!is_lf)
            run_next = 2'd0;
        else if (squeeze_reg && (run_fs != RUN_MAX))
            run_next = run_fs + 2'd1;
        else
            run_next = run_fs;

        if (tab_caret)
        begin
            body0_next = CH_CARET;
            body1_next = CH_I;
        end
        else if (end_mark)
        begin
            body0_next = CH_DOLLAR;
            body1_next = in_byte;
        end
        else if (ctrl_caret)
        begin
            body0_next = CH_CARET;
            body1_next = in_byte + CTRL_OFFSET;
        end
        else
        begin
            body0_next = in_byte;
            body1_next = in_byte;
        end
        body_two_next = tab_caret || end_mark || ctrl_caret;

        als_next   = drop ? als_fs : is_lf;
        count_next = (!drop && num && !all_nines) ? count_inc : count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            run_reg      <= 2'd0;
            als_reg      <= 1'b1;
            body_two_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            count_reg    <= count_next;
            run_reg      <= run_next;
            als_reg      <= als_next;
            body_two_reg <= body_two_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            body0_reg <= body0_next;
            body1_reg <= body1_next;
        end
    end

    always_comb
    begin
        if (cmd.phase_num)
            out_byte_next = prefix_chars[cmd.idx];
        else if (cmd.idx[0])
            out_byte_next = body1_reg;
        else
            out_byte_next = body0_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_byte_reg <= out_byte_next;
            last_reg     <= cmd.last;
        end
    end

    assign status.drop     = drop;
    assign status.num      = num;
    assign status.body_two = body_two_reg;
    assign out_byte        = out_byte_reg;
    assign last_of_run     = last_reg;

endmodule

// ===== sv/text_stream_line_formatter.sv =====
// Channel | Role   | Word contents
// --------+--------+-------------------------------------------
// raw     | sink   | in_byte[7:0], file_start
// fmt     | source | out_byte[7:0], last_of_run
// cfg     | sink   | index[2:0], data (always ready)
//
// An input word is first accepted, then the sequencer walks its output words
// through one output register: a plain byte gives one word, a number prefix
// adds NUMBER_DIGITS + 2 words and the body may be two words long; a
// squeezed newline gives no output word.
// rst_n is asynchronous, active low; counter 0, line start set, options off.
// A stall on fmt holds the sequencer; raw is ready only between runs.
module text_stream_line_formatter
(
    input  logic        clk,
    input  logic        rst_n,
    tslf_in_if.sink     raw,
    tslf_out_if.source  fmt,
    tslf_cfg_if.sink    cfg
);
    import tslf_pkg::*;

    tslf_cmd_t    cmd;
    tslf_status_t status;
    logic         cfg_we;

    // config registers take a write in any cycle
    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid;

    // sequencer: accept, number prefix, body
    tslf_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (raw.valid),
        .in_ready  (raw.ready),
        .out_ready (fmt.ready),
        .out_valid (fmt.valid),
        .cmd       (cmd),
        .status    (status)
    );

    // line state, BCD counter, body words, output word register
    tslf_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data),
        .in_byte     (raw.in_byte),
        .file_start  (raw.file_start),
        .cmd         (cmd),
        .status      (status),
        .out_byte    (fmt.out_byte),
        .last_of_run (fmt.last_of_run)
    );

endmodule

// ===== sv/tslf_checker.sv =====
`include "text_stream_line_formatter_defines.svh"

module tslf_checker
(
    input logic clk,
    input logic rst_n,
    input logic raw_ready,
    input logic fmt_valid,
    input logic fmt_ready,
    input logic fmt_last
);

    // stalled output word stays offered
    `TSLF_ASSERT_NEXT(a_out_hold, fmt_valid && !fmt_ready, fmt_valid, "fmt word dropped")

    // no new input while a run is still going out
    `TSLF_ASSERT_NOW(a_no_accept_mid_run, fmt_valid && !fmt_last, !raw_ready, "raw ready mid-run")

    // a run continues without a gap once a word is taken
    `TSLF_ASSERT_NEXT(a_run_gapless, fmt_valid && fmt_ready && !fmt_last, fmt_valid, "gap in run")

    // input reopens only with the final word of a run on the output
    `TSLF_ASSERT_NOW(a_reopen_on_last, $rose(raw_ready), fmt_valid && fmt_last, "early reopen")

endmodule

bind text_stream_line_formatter tslf_checker u_tslf_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .raw_ready (raw.ready),
    .fmt_valid (fmt.valid),
    .fmt_ready (fmt.ready),
    .fmt_last  (fmt.last_of_run)
);
